// ===== src/bia_pkg.sv =====
// Package for the baro/inertial altitude estimator: types, constants, helpers.
package bia_pkg;

    localparam logic signed [31:0] ONE_G_Q16 = 32'sd642690;

    localparam logic [2:0] REG_POS_W  = 3'd0;
    localparam logic [2:0] REG_VEL_W  = 3'd1;
    localparam logic [2:0] REG_BIAS_W = 3'd2;
    localparam logic [2:0] REG_C2B_W  = 3'd3;
    localparam logic [2:0] REG_BOFF_W = 3'd4;
    localparam logic [2:0] REG_CHK_V  = 3'd5;

    // Datapath operation codes, one per controller step.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DOT0,
        OP_DOT1,
        OP_DOT2,
        OP_AZ,
        OP_ADT,
        OP_ADT2,
        OP_VDT,
        OP_AVDT,
        OP_LEAK,
        OP_BOFF,
        OP_CORR,
        OP_VBC,
        OP_BB0,
        OP_BB1,
        OP_BB2,
        OP_GR0,
        OP_GR1,
        OP_GR2,
        OP_POS,
        OP_VEL
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic [15:0]        pos_weight;
        logic [15:0]        vel_weight;
        logic [15:0]        bias_weight;
        logic [15:0]        corr_to_bias_weight;
        logic [15:0]        baro_offset_weight;
        logic signed [31:0] check_velocity;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Round-to-nearest, ties away from zero, shift by s.
    function automatic logic signed [65:0] rshr(input logic signed [65:0] v,
                                                input logic [5:0] s);
        logic [65:0] mag;
        logic [65:0] r;
        mag = v[65] ? 66'(-v) : 66'(v);
        r = (mag + (66'd1 << (s - 6'd1))) >> s;
        return v[65] ? -$signed(r) : $signed(r);
    endfunction

endpackage

// ===== src/bia_ctrl.sv =====
// Controller that sequences one estimator step through the shared datapath.
module bia_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bia_pkg::t_cmd o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;

    t_state       r_state;
    bia_pkg::t_op r_op;
    logic         r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = i_in_valid && o_in_ready;
    assign o_cmd.op    = (r_state == S_RUN) ? r_op : bia_pkg::OP_NONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= bia_pkg::OP_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_state <= S_RUN;
                        r_op    <= bia_pkg::OP_DOT0;
                    end
                end
                S_RUN: begin
                    if (r_op == bia_pkg::OP_VEL) begin
                        r_state <= S_DONE;
                    end else begin
                        r_op <= bia_pkg::t_op'(r_op + 5'd1);
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/bia_dp.sv =====
// Datapath: one operation step per cycle over the estimator state; most steps use the shared multiplier.
module bia_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bia_pkg::t_cmd      i_cmd,
    input  bia_pkg::t_cfg      i_cfg,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [15:0] i_rx,
    input  logic signed [15:0] i_ry,
    input  logic signed [15:0] i_rz,
    input  logic signed [31:0] i_baro,
    input  logic [15:0]        i_dt,
    output logic signed [31:0] o_alt,
    output logic signed [31:0] o_vel,
    output logic signed [31:0] o_up
);
    logic signed [31:0] r_a [3];
    logic signed [15:0] r_r [3];
    logic signed [31:0] r_baro;
    logic [15:0]        r_dt;
    logic [31:0]        r_gain;
    logic signed [65:0] r_acc;
    logic signed [31:0] r_azc, r_up, r_adt, r_adt2, r_corr;
    logic signed [31:0] r_alt, r_vel, r_aoa, r_aov, r_vbc;
    logic signed [31:0] r_bb [3];
    logic               r_seeded;

    logic signed [65:0] w_m;
    logic signed [65:0] w_g;
    logic signed [31:0] w_b;
    logic signed [31:0] w_mx;
    logic signed [31:0] w_my;
    logic [1:0]         w_i;

    assign o_alt = r_alt;
    assign o_vel = r_vel;
    assign o_up  = r_up;

    always_comb begin
        w_mx = 32'sd0;
        w_my = 32'sd0;
        w_i  = 2'd0;
        unique case (i_cmd.op)
            bia_pkg::OP_DOT0: begin w_mx = r_a[0]; w_my = 32'(r_r[0]); end
            bia_pkg::OP_DOT1: begin w_mx = r_a[1]; w_my = 32'(r_r[1]); end
            bia_pkg::OP_DOT2: begin w_mx = r_a[2]; w_my = 32'(r_r[2]); end
            bia_pkg::OP_ADT:  begin w_mx = r_azc; w_my = $signed({16'd0, r_dt}); end
            bia_pkg::OP_VDT:  begin w_mx = r_vel; w_my = $signed({16'd0, r_dt}); end
            bia_pkg::OP_AVDT: begin w_mx = r_aov; w_my = $signed({16'd0, r_dt}); end
            bia_pkg::OP_BOFF: begin
                w_mx = r_baro; w_my = $signed({16'd0, i_cfg.baro_offset_weight});
            end
            bia_pkg::OP_LEAK: begin
                w_mx = bia_pkg::sat32(66'(r_aov) - 66'(r_adt));
                w_my = $signed({16'd0, i_cfg.bias_weight});
            end
            bia_pkg::OP_VBC: begin
                w_mx = r_corr; w_my = $signed({16'd0, i_cfg.corr_to_bias_weight});
            end
            bia_pkg::OP_BB0: begin w_mx = r_vbc; w_my = 32'(r_r[0]); w_i = 2'd0; end
            bia_pkg::OP_BB1: begin w_mx = r_vbc; w_my = 32'(r_r[1]); w_i = 2'd1; end
            bia_pkg::OP_BB2: begin w_mx = r_vbc; w_my = 32'(r_r[2]); w_i = 2'd2; end
            bia_pkg::OP_GR0: w_i = 2'd0;
            bia_pkg::OP_GR1: w_i = 2'd1;
            bia_pkg::OP_GR2: w_i = 2'd2;
            bia_pkg::OP_POS: begin
                w_mx = r_corr; w_my = $signed({16'd0, i_cfg.pos_weight});
            end
            bia_pkg::OP_VEL: begin
                w_mx = r_corr; w_my = $signed({16'd0, i_cfg.vel_weight});
            end
            default: ;
        endcase
        w_m = 66'(w_mx) * 66'(w_my);
        w_b = bia_pkg::sat32(bia_pkg::rshr(w_m, 6'd14));
        w_g = 66'(r_bb[w_i]) * $signed({34'd0, r_gain});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt <= '0; r_vel <= '0; r_aoa <= '0; r_aov <= '0; r_vbc <= '0;
            r_bb[0] <= '0; r_bb[1] <= '0; r_bb[2] <= '0;
            r_seeded <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_a[0] <= bia_pkg::sat32(66'(i_ax) - 66'(r_bb[0]));
                r_a[1] <= bia_pkg::sat32(66'(i_ay) - 66'(r_bb[1]));
                r_a[2] <= bia_pkg::sat32(66'(i_az) - 66'(r_bb[2]));
                r_r[0] <= i_rx; r_r[1] <= i_ry; r_r[2] <= i_rz;
                r_baro <= i_baro;
                r_dt   <= i_dt;
                r_gain <= 32'(i_cfg.bias_weight) * 32'(i_dt);
                r_acc  <= '0;
            end
            unique case (i_cmd.op)
                bia_pkg::OP_DOT0, bia_pkg::OP_DOT1, bia_pkg::OP_DOT2:
                    r_acc <= r_acc + w_m;
                bia_pkg::OP_AZ: begin
                    r_azc <= bia_pkg::sat32(66'(bia_pkg::sat32(
                        bia_pkg::rshr(r_acc, 6'd14))) + 66'(bia_pkg::ONE_G_Q16));
                end
                bia_pkg::OP_ADT: begin
                    r_up  <= bia_pkg::sat32(-66'(r_azc));
                    r_adt <= 32'(bia_pkg::rshr(w_m, 6'd16));
                    r_acc <= w_m;
                end
                bia_pkg::OP_ADT2:
                    r_adt2 <= 32'(bia_pkg::rshr(
                        66'(r_acc * $signed({50'd0, r_dt})), 6'd33));
                bia_pkg::OP_VDT: begin
                    r_alt <= bia_pkg::sat32(66'(r_alt) +
                        bia_pkg::rshr(w_m, 6'd16) + 66'(r_adt2));
                    r_vel <= bia_pkg::sat32(66'(r_vel) + 66'(r_adt));
                end
                bia_pkg::OP_AVDT: begin
                    r_aoa <= bia_pkg::sat32(66'(r_aoa) +
                        bia_pkg::rshr(w_m, 6'd16) + 66'(r_adt2));
                    r_aov <= bia_pkg::sat32(66'(r_aov) + 66'(r_adt));
                end
                bia_pkg::OP_LEAK:
                    r_aov <= bia_pkg::sat32(66'(r_aov) -
                        66'(bia_pkg::sat32(bia_pkg::rshr(w_m, 6'd16))));
                bia_pkg::OP_BOFF:
                    r_acc <= 66'(bia_pkg::sat32(66'(r_aoa) -
                        bia_pkg::rshr(w_m, 6'd16)));
                bia_pkg::OP_CORR: begin
                    if (r_vel < i_cfg.check_velocity) begin
                        r_corr <= bia_pkg::sat32(-66'(r_baro) + r_acc - 66'(r_alt));
                    end else begin
                        r_corr <= bia_pkg::sat32(-66'(r_baro) - 66'(r_alt));
                    end
                end
                bia_pkg::OP_VBC: begin
                    if (!r_seeded) begin
                        r_vbc <= r_azc;
                    end else begin
                        r_vbc <= bia_pkg::sat32(66'(r_vbc) - bia_pkg::rshr(w_m, 6'd16));
                    end
                end
                bia_pkg::OP_BB0, bia_pkg::OP_BB1, bia_pkg::OP_BB2:
                    r_bb[w_i] <= w_b;
                // growth term applies only once the bias has been seeded
                bia_pkg::OP_GR0, bia_pkg::OP_GR1, bia_pkg::OP_GR2: begin
                    if (r_seeded) begin
                        r_bb[w_i] <= bia_pkg::sat32(66'(r_bb[w_i]) +
                            bia_pkg::rshr(w_g, 6'd32));
                    end else if (i_cmd.op == bia_pkg::OP_GR2) begin
                        r_seeded <= 1'b1;
                    end
                end
                bia_pkg::OP_POS:
                    r_alt <= bia_pkg::sat32(66'(r_alt) + bia_pkg::rshr(w_m, 6'd16));
                bia_pkg::OP_VEL:
                    r_vel <= bia_pkg::sat32(66'(r_vel) + bia_pkg::rshr(w_m, 6'd16));
                default: ;
            endcase
        end
    end
endmodule

// ===== src/baro_inertial_altitude_estimator.sv =====
// Top level of the baro/inertial vertical altitude estimator.
// Per step, once an input is accepted, the controller walks 20 operations
// through the datapath, one per cycle, then passes through a done state
// that raises the result valid. Input is taken again only once the result
// has been accepted, so a new item is never taken while one is in flight.
// Configuration writes are taken at any time, but should only be
// issued between steps.
module baro_inertial_altitude_estimator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // accel_x, accel_y, accel_z, rot_zx, rot_zy, rot_zz, baro_altitude, step_time
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // altitude, velocity, up_accel
    output logic [95:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    bia_pkg::t_cmd w_cmd;
    bia_pkg::t_cfg r_cfg;
    logic signed [31:0] w_alt, w_vel, w_up;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bia_pkg::REG_POS_W:  r_cfg.pos_weight <= i_cfg_data[15:0];
                bia_pkg::REG_VEL_W:  r_cfg.vel_weight <= i_cfg_data[15:0];
                bia_pkg::REG_BIAS_W: r_cfg.bias_weight <= i_cfg_data[15:0];
                bia_pkg::REG_C2B_W:  r_cfg.corr_to_bias_weight <= i_cfg_data[15:0];
                bia_pkg::REG_BOFF_W: r_cfg.baro_offset_weight <= i_cfg_data[15:0];
                bia_pkg::REG_CHK_V:  r_cfg.check_velocity <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bia_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(w_cmd)
    );

    bia_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_cfg(r_cfg),
        .i_ax(s_axis_tdata[31:0]), .i_ay(s_axis_tdata[63:32]),
        .i_az(s_axis_tdata[95:64]), .i_rx(s_axis_tdata[111:96]),
        .i_ry(s_axis_tdata[127:112]), .i_rz(s_axis_tdata[143:128]),
        .i_baro(s_axis_tdata[175:144]), .i_dt(s_axis_tdata[191:176]),
        .o_alt(w_alt), .o_vel(w_vel), .o_up(w_up)
    );

    assign m_axis_tdata = {w_up, w_vel, w_alt};

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
        else $error("controller did not start");
endmodule
